@@ rtl/core/shll_pkg.sv @@
// Shared constants of the split-flux unit: default formats and register reset.
package shll_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 20;
  localparam int GAS_WIDTH      = 31;
  localparam logic [GAS_WIDTH-1:0] GAS_RESET = 31'd1048576;

endpackage

@@ rtl/core/shll_split_flux_unit.sv @@
// Pipelined split-flux unit: pressure, Mach number, weights and split fluxes.
//
//  port group | dir | beat content
//  -----------+-----+--------------------------------------------------------
//  in_        | in  | nine fixed-point primitives/conserved values, direction
//  out_       | out | four plus and four minus split fluxes, saturation flag
//  cfg_       | in  | gas constant R, written whenever cfg_wen is high
//
// One beat enters per clock while the output is not stalled; formats default
// to Q12.20. The quotient v_n/a is resolved one bit per stage in a pipelined
// restoring divider; the other stages capture the beat, multiply, round and
// saturate, or add and subtract with saturation.
// rst_n clears the valid bits, holds in_tready low and loads R with 1.0;
// payload registers keep junk. A stall on the output freezes every stage in
// place, so no beat is dropped or repeated.
module shll_split_flux_unit
  import shll_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // cfg: gas_constant
  input  logic                                   cfg_wen,
  input  logic [GAS_WIDTH-1:0]                   cfg_wdata,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // tdata, low to high: density, velocity_x, velocity_y, temperature,
  // sound_speed, cons_mass, cons_mom_x, cons_mom_y, cons_energy, zero pad
  input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]      in_tdata,
  // tuser: direction
  input  logic                                   in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // tdata, low to high: plus_mass, plus_mom_x, plus_mom_y, plus_energy,
  // minus_mass, minus_mom_x, minus_mom_y, minus_energy
  output logic [8*DATA_WIDTH-1:0]                out_tdata,
  // tuser: saturated
  output logic                                   out_tuser
);

  localparam int DW = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * DW;
  localparam int NW = DW + F + 1;       // width of the shifted dividend

  typedef logic signed [DW-1:0] fx_t;
  typedef logic signed [PW-1:0] prod_t;

  typedef struct packed {
    logic sat;
    fx_t  v;
  } res_t;

  typedef struct packed {
    logic           ydir;
    logic           sat;
    fx_t            rho;
    fx_t            vx;
    fx_t            vy;
    fx_t            t;
    fx_t            a;
    fx_t            r;
    fx_t            vn;
    fx_t            mom;
    fx_t [3:0]      u;
    logic [DW-1:0]  nm;
    logic [DW-1:0]  dm;
    logic           dz;
    logic           dneg;
    logic [DW:0]    rem;
    logic [NW-1:0]  q;
    prod_t [11:0]   pr;
    fx_t            t1;
    fx_t            mvx;
    fx_t            mvy;
    fx_t            ha;
    fx_t            p;
    fx_t            e;
    fx_t [3:0]      f;
    fx_t            m;
    fx_t            a1;
    fx_t            s1;
    fx_t            mm;
    fx_t            d;
    fx_t            z1;
    fx_t            z2;
    fx_t            z3;
    fx_t [3:0]      fz1;
    fx_t [3:0]      fz3;
    fx_t [3:0]      uz;
    fx_t [3:0]      nfz3;
    fx_t [3:0]      pl;
    fx_t [3:0]      mi;
  } item_t;

  localparam fx_t FX_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam fx_t ONE  = (F >= DW - 1) ? FX_MAX : ({{(DW-1){1'b0}}, 1'b1} << F);
  localparam fx_t HALF = (F - 1 >= DW - 1) ? FX_MAX : ({{(DW-1){1'b0}}, 1'b1} << (F - 1));

  // stage map
  localparam int DV0 = 8;               // first divider stage
  localparam int Q0  = DV0 + NW;        // first stage after the divider
  localparam int NST = Q0 + 10;

  function automatic prod_t smul(fx_t x, fx_t y);
    return prod_t'(x) * prod_t'(y);
  endfunction

  // round half away from zero, drop FRAC_BITS, saturate
  function automatic res_t rnd(prod_t p);
    logic          neg;
    logic [PW-1:0] mg;
    logic [PW:0]   qv;
    logic [PW:0]   lim;
    res_t          o;
    neg = p[PW-1];
    mg  = neg ? (~p + 1'b1) : p;
    qv  = ({1'b0, mg} + ((PW+1)'(1) << (F - 1))) >> F;
    lim = ((PW+1)'(1) << (DW - 1)) - (neg ? (PW+1)'(0) : (PW+1)'(1));
    if (qv > lim) begin
      o.sat = 1'b1;
      o.v   = neg ? FX_MIN : FX_MAX;
    end else begin
      o.sat = 1'b0;
      o.v   = neg ? fx_t'(~qv[DW-1:0] + 1'b1) : fx_t'(qv[DW-1:0]);
    end
    return o;
  endfunction

  function automatic res_t sadd(fx_t x, fx_t y);
    logic [DW:0] s;
    res_t        o;
    s = {x[DW-1], x} + {y[DW-1], y};
    o.sat = s[DW] ^ s[DW-1];
    o.v   = o.sat ? (s[DW] ? FX_MIN : FX_MAX) : fx_t'(s[DW-1:0]);
    return o;
  endfunction

  function automatic res_t ssub(fx_t x, fx_t y);
    logic [DW:0] s;
    res_t        o;
    s = {x[DW-1], x} - {y[DW-1], y};
    o.sat = s[DW] ^ s[DW-1];
    o.v   = o.sat ? (s[DW] ? FX_MIN : FX_MAX) : fx_t'(s[DW-1:0]);
    return o;
  endfunction

  function automatic res_t sneg(fx_t x);
    res_t o;
    o.sat = (x == FX_MIN);
    o.v   = o.sat ? FX_MAX : fx_t'(-x);
    return o;
  endfunction

  logic [GAS_WIDTH-1:0] gas_r;
  logic [NST-1:0]       vld_r;
  item_t                stg_r   [NST];
  item_t                stg_nxt [NST];
  logic [NW-1:0]        dbit;
  logic                 adv;

  // hold every stage while the output beat waits
  assign adv       = !(vld_r[NST-1] && !out_tready);
  assign in_tready = adv && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gas_r <= GAS_RESET;
    end else if (cfg_wen) begin
      gas_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NST; k++) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  // capture: unpack, clamp R, pick normal direction, set up divider operands
  always_comb begin : s0_c
    logic [63:0] g64;
    fx_t         vsel;
    fx_t         asel;
    stg_nxt[0]      = '0;
    stg_nxt[0].ydir = in_tuser;
    stg_nxt[0].rho  = fx_t'(in_tdata[0*DW +: DW]);
    stg_nxt[0].vx   = fx_t'(in_tdata[1*DW +: DW]);
    stg_nxt[0].vy   = fx_t'(in_tdata[2*DW +: DW]);
    stg_nxt[0].t    = fx_t'(in_tdata[3*DW +: DW]);
    stg_nxt[0].a    = fx_t'(in_tdata[4*DW +: DW]);
    for (int k = 0; k < 4; k++) begin
      stg_nxt[0].u[k] = fx_t'(in_tdata[(5+k)*DW +: DW]);
    end
    g64 = 64'(gas_r);
    if (g64 > 64'(FX_MAX)) begin
      stg_nxt[0].r   = FX_MAX;
      stg_nxt[0].sat = 1'b1;
    end else begin
      stg_nxt[0].r   = fx_t'(g64[DW-1:0]);
    end
    vsel = in_tuser ? fx_t'(in_tdata[2*DW +: DW]) : fx_t'(in_tdata[1*DW +: DW]);
    asel = fx_t'(in_tdata[4*DW +: DW]);
    stg_nxt[0].vn   = vsel;
    stg_nxt[0].mom  = in_tuser ? fx_t'(in_tdata[7*DW +: DW])
                               : fx_t'(in_tdata[6*DW +: DW]);
    stg_nxt[0].nm   = vsel[DW-1] ? (~vsel + 1'b1) : vsel;
    stg_nxt[0].dm   = asel[DW-1] ? (~asel + 1'b1) : asel;
    stg_nxt[0].dz   = (asel == '0);
    stg_nxt[0].dneg = vsel[DW-1] ^ asel[DW-1];
  end

  always_comb begin : s1_c
    stg_nxt[1]       = stg_r[0];
    stg_nxt[1].pr[0] = smul(stg_r[0].rho, stg_r[0].r);
    stg_nxt[1].pr[1] = smul(stg_r[0].mom, stg_r[0].vx);
    stg_nxt[1].pr[2] = smul(stg_r[0].mom, stg_r[0].vy);
    stg_nxt[1].pr[3] = smul(HALF, stg_r[0].a);
  end

  always_comb begin : s2_c
    res_t r0;
    res_t r1;
    res_t r2;
    res_t r3;
    r0 = rnd(stg_r[1].pr[0]);
    r1 = rnd(stg_r[1].pr[1]);
    r2 = rnd(stg_r[1].pr[2]);
    r3 = rnd(stg_r[1].pr[3]);
    stg_nxt[2]     = stg_r[1];
    stg_nxt[2].t1  = r0.v;
    stg_nxt[2].mvx = r1.v;
    stg_nxt[2].mvy = r2.v;
    stg_nxt[2].ha  = r3.v;
    stg_nxt[2].sat = stg_r[1].sat | r0.sat | r1.sat | r2.sat | r3.sat;
  end

  always_comb begin : s3_c
    stg_nxt[3]       = stg_r[2];
    stg_nxt[3].pr[0] = smul(stg_r[2].t1, stg_r[2].t);
  end

  always_comb begin : s4_c
    res_t r0;
    r0 = rnd(stg_r[3].pr[0]);
    stg_nxt[4]     = stg_r[3];
    stg_nxt[4].p   = r0.v;
    stg_nxt[4].sat = stg_r[3].sat | r0.sat;
  end

  // Euler fluxes: pressure joins the normal momentum component and the energy
  always_comb begin : s5_c
    res_t r1;
    res_t r2;
    res_t re;
    r1 = sadd(stg_r[4].mvx, stg_r[4].ydir ? fx_t'('0) : stg_r[4].p);
    r2 = sadd(stg_r[4].mvy, stg_r[4].ydir ? stg_r[4].p : fx_t'('0));
    re = sadd(stg_r[4].u[3], stg_r[4].p);
    stg_nxt[5]      = stg_r[4];
    stg_nxt[5].f[0] = stg_r[4].mom;
    stg_nxt[5].f[1] = r1.v;
    stg_nxt[5].f[2] = r2.v;
    stg_nxt[5].e    = re.v;
    stg_nxt[5].sat  = stg_r[4].sat | r1.sat | r2.sat | re.sat;
  end

  always_comb begin : s6_c
    stg_nxt[6]       = stg_r[5];
    stg_nxt[6].pr[0] = smul(stg_r[5].vn, stg_r[5].e);
  end

  always_comb begin : s7_c
    res_t r0;
    r0 = rnd(stg_r[6].pr[0]);
    stg_nxt[7]      = stg_r[6];
    stg_nxt[7].f[3] = r0.v;
    stg_nxt[7].sat  = stg_r[6].sat | r0.sat;
    stg_nxt[7].rem  = '0;
    stg_nxt[7].q    = '0;
  end

  // restoring divider, one quotient bit per stage, MSB first
  for (genvar i = 0; i < NW; i++) begin : g_div
    localparam int J = NW - 1 - i;
    if (J >= F + 1) begin : g_nb
      assign dbit[i] = stg_r[DV0+i-1].nm[J-F-1];
    end else begin : g_zb
      assign dbit[i] = 1'b0;
    end

    always_comb begin : dv_c
      logic [DW:0] rs;
      rs = {stg_r[DV0+i-1].rem[DW-1:0], dbit[i]};
      stg_nxt[DV0+i] = stg_r[DV0+i-1];
      if (rs >= {1'b0, stg_r[DV0+i-1].dm}) begin
        stg_nxt[DV0+i].rem = rs - {1'b0, stg_r[DV0+i-1].dm};
        stg_nxt[DV0+i].q   = {stg_r[DV0+i-1].q[NW-2:0], 1'b1};
      end else begin
        stg_nxt[DV0+i].rem = rs;
        stg_nxt[DV0+i].q   = {stg_r[DV0+i-1].q[NW-2:0], 1'b0};
      end
    end
  end

  // Mach number: round the extra quotient bit, saturate, or handle a = 0
  always_comb begin : q0_c
    logic [NW-1:0] q2;
    logic [NW-1:0] lim;
    item_t         it;
    it  = stg_r[Q0-1];
    q2  = {1'b0, it.q[NW-1:1]} + NW'(it.q[0]);
    lim = (NW'(1) << (DW - 1)) - (it.dneg ? NW'(0) : NW'(1));
    stg_nxt[Q0] = it;
    if (it.dz) begin
      stg_nxt[Q0].sat = 1'b1;
      stg_nxt[Q0].m   = (it.vn == '0) ? fx_t'('0) : (it.vn[DW-1] ? FX_MIN : FX_MAX);
    end else if (q2 > lim) begin
      stg_nxt[Q0].sat = 1'b1;
      stg_nxt[Q0].m   = it.dneg ? FX_MIN : FX_MAX;
    end else begin
      stg_nxt[Q0].m   = it.dneg ? fx_t'(~q2[DW-1:0] + 1'b1) : fx_t'(q2[DW-1:0]);
    end
  end

  always_comb begin : q1_c
    res_t ra;
    res_t rs;
    ra = sadd(stg_r[Q0].m, ONE);
    rs = ssub(stg_r[Q0].m, ONE);
    stg_nxt[Q0+1]       = stg_r[Q0];
    stg_nxt[Q0+1].pr[0] = smul(stg_r[Q0].m, stg_r[Q0].m);
    stg_nxt[Q0+1].a1    = ra.v;
    stg_nxt[Q0+1].s1    = rs.v;
    stg_nxt[Q0+1].sat   = stg_r[Q0].sat | ra.sat | rs.sat;
  end

  always_comb begin : q2_c
    res_t r0;
    r0 = rnd(stg_r[Q0+1].pr[0]);
    stg_nxt[Q0+2]       = stg_r[Q0+1];
    stg_nxt[Q0+2].mm    = r0.v;
    stg_nxt[Q0+2].pr[1] = smul(HALF, stg_r[Q0+1].a1);
    stg_nxt[Q0+2].pr[2] = smul(HALF, stg_r[Q0+1].s1);
    stg_nxt[Q0+2].sat   = stg_r[Q0+1].sat | r0.sat;
  end

  always_comb begin : q3_c
    res_t rd;
    res_t r1;
    res_t r3;
    rd = ssub(ONE, stg_r[Q0+2].mm);
    r1 = rnd(stg_r[Q0+2].pr[1]);
    r3 = rnd(stg_r[Q0+2].pr[2]);
    stg_nxt[Q0+3]     = stg_r[Q0+2];
    stg_nxt[Q0+3].d   = rd.v;
    stg_nxt[Q0+3].z1  = r1.v;
    stg_nxt[Q0+3].z3  = r3.v;
    stg_nxt[Q0+3].sat = stg_r[Q0+2].sat | rd.sat | r1.sat | r3.sat;
  end

  always_comb begin : q4_c
    stg_nxt[Q0+4]       = stg_r[Q0+3];
    stg_nxt[Q0+4].pr[0] = smul(stg_r[Q0+3].ha, stg_r[Q0+3].d);
  end

  always_comb begin : q5_c
    res_t r0;
    r0 = rnd(stg_r[Q0+4].pr[0]);
    stg_nxt[Q0+5]     = stg_r[Q0+4];
    stg_nxt[Q0+5].z2  = r0.v;
    stg_nxt[Q0+5].sat = stg_r[Q0+4].sat | r0.sat;
  end

  // twelve products of fluxes and conserved values with the weights
  always_comb begin : q6_c
    stg_nxt[Q0+6] = stg_r[Q0+5];
    for (int k = 0; k < 4; k++) begin
      stg_nxt[Q0+6].pr[k]   = smul(stg_r[Q0+5].f[k], stg_r[Q0+5].z1);
      stg_nxt[Q0+6].pr[4+k] = smul(stg_r[Q0+5].f[k], stg_r[Q0+5].z3);
      stg_nxt[Q0+6].pr[8+k] = smul(stg_r[Q0+5].u[k], stg_r[Q0+5].z2);
    end
  end

  always_comb begin : q7_c
    res_t ra;
    res_t rb;
    res_t rc;
    logic s;
    stg_nxt[Q0+7] = stg_r[Q0+6];
    s = stg_r[Q0+6].sat;
    for (int k = 0; k < 4; k++) begin
      ra = rnd(stg_r[Q0+6].pr[k]);
      rb = rnd(stg_r[Q0+6].pr[4+k]);
      rc = rnd(stg_r[Q0+6].pr[8+k]);
      stg_nxt[Q0+7].fz1[k] = ra.v;
      stg_nxt[Q0+7].fz3[k] = rb.v;
      stg_nxt[Q0+7].uz[k]  = rc.v;
      s = s | ra.sat | rb.sat | rc.sat;
    end
    stg_nxt[Q0+7].sat = s;
  end

  always_comb begin : q8_c
    res_t ra;
    res_t rb;
    logic s;
    stg_nxt[Q0+8] = stg_r[Q0+7];
    s = stg_r[Q0+7].sat;
    for (int k = 0; k < 4; k++) begin
      ra = sadd(stg_r[Q0+7].fz1[k], stg_r[Q0+7].uz[k]);
      rb = sneg(stg_r[Q0+7].fz3[k]);
      stg_nxt[Q0+8].pl[k]   = ra.v;
      stg_nxt[Q0+8].nfz3[k] = rb.v;
      s = s | ra.sat | rb.sat;
    end
    stg_nxt[Q0+8].sat = s;
  end

  always_comb begin : q9_c
    res_t ra;
    logic s;
    stg_nxt[Q0+9] = stg_r[Q0+8];
    s = stg_r[Q0+8].sat;
    for (int k = 0; k < 4; k++) begin
      ra = ssub(stg_r[Q0+8].nfz3[k], stg_r[Q0+8].uz[k]);
      stg_nxt[Q0+9].mi[k] = ra.v;
      s = s | ra.sat;
    end
    stg_nxt[Q0+9].sat = s;
  end

  // last stage is the output register
  assign out_tvalid = vld_r[NST-1];
  assign out_tuser  = stg_r[NST-1].sat;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      out_tdata[k*DW +: DW]     = stg_r[NST-1].pl[k];
      out_tdata[(4+k)*DW +: DW] = stg_r[NST-1].mi[k];
    end
  end

endmodule
